// File: rtl/core/fsmd_pkg.sv
// ----------------------------------------------------------------------------
// fsmd_pkg - shared types and constants
// Widths, register indexes and small helpers for the frame SAD motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

package fsmd_pkg;

    // sample store capacity
    localparam int MAX_SAMPLES = 131072;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int SIDX_W      = $clog2(MAX_SAMPLES + 1);

    // pixel and result fields
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int SAD_W    = 27;
    localparam int COUNT_W  = 18;
    localparam int DIFF_W   = 10;

    // configuration registers
    localparam int GEOM_W   = 13;
    localparam int POS_W    = 12;
    localparam int STEP_W   = 5;
    localparam int PHASE_W  = 4;
    localparam int THR_W    = 10;
    localparam int PROD_W   = THR_W + SIDX_W;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [GEOM_W-1:0] GEOM_MAX = GEOM_W'(4096);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(16);

    localparam logic [GEOM_W-1:0] RESET_WIDTH  = GEOM_W'(640);
    localparam logic [GEOM_W-1:0] RESET_HEIGHT = GEOM_W'(480);
    localparam logic [STEP_W-1:0] RESET_STEP   = STEP_W'(4);
    localparam logic [THR_W-1:0]  RESET_THR    = THR_W'(20);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH      = 4'd0,
        REG_FRAME_HEIGHT     = 4'd1,
        REG_SUBSAMPLE_STEP   = 4'd2,
        REG_MOTION_THRESHOLD = 4'd3
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pixel_t;

    function automatic logic [CHAN_W-1:0] abs_diff8(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fsmd_ifs.sv
// ----------------------------------------------------------------------------
// fsmd_ifs - channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsmd_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [fsmd_pkg::CHAN_W-1:0]     red;
    logic [fsmd_pkg::CHAN_W-1:0]     green;
    logic [fsmd_pkg::CHAN_W-1:0]     blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface fsmd_result_if;
    logic                            valid;
    logic                            ready;
    logic                            motion;
    logic [fsmd_pkg::SAD_W-1:0]      sad_total;
    logic [fsmd_pkg::COUNT_W-1:0]    sample_count;
    logic                            had_reference;

    modport source (output valid, output motion, output sad_total, output sample_count,
                    output had_reference, input ready);
    modport sink   (input valid, input motion, input sad_total, input sample_count,
                    input had_reference, output ready);
endinterface

interface fsmd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fsmd_pkg::CFG_INDEX_W-1:0]  index;
    logic [fsmd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/fsmd_ram.sv
// ----------------------------------------------------------------------------
// fsmd_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/frame_sad_motion_detector.sv
// ----------------------------------------------------------------------------
// frame_sad_motion_detector - subsampled frame SAD motion detector
// Compares subsampled RGB pixels against the previous frame held in a RAM
// and reports the SAD total and a motion flag once per frame.
// ----------------------------------------------------------------------------
//
//  channel     dir  handshake        payload
//  ---------   ---  ---------------  ------------------------------------------
//  pixel_in    in   valid / ready    red, green, blue (8 b each)
//  result_out  out  valid / ready    motion, sad_total, sample_count, had_reference
//  cfg         in   valid / ready    index (register), data
//
//  One pixel transaction per clock while ready is high. An accepted pixel reads
//  the store; stage 1 then accumulates the SAD and writes the new sample back
//  (forwarded to a read of the same entry issued with the write); a frame-end
//  result passes stage 2 before it reaches the output register.
//  ready drops only while a frame-end pixel in stage 1 waits behind an earlier
//  result that has not been taken; no further pixels are accepted meanwhile.
//  Reset (rst_n, async) clears counters and the reference flag; the store is
//  not cleared - the first frame after reset or any config write fills it.
//  cfg is always ready; writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_sad_motion_detector (
    input  wire logic      clk,
    input  wire logic      rst_n,
    fsmd_pixel_if.sink     pixel_in,
    fsmd_result_if.source  result_out,
    fsmd_cfg_if.sink       cfg
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [fsmd_pkg::GEOM_W-1:0] width_reg,  width_next;
    logic [fsmd_pkg::GEOM_W-1:0] height_reg, height_next;
    logic [fsmd_pkg::STEP_W-1:0] step_reg,   step_next;
    logic [fsmd_pkg::THR_W-1:0]  thr_reg,    thr_next;
    logic                        cfg_write;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid & cfg.ready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        step_next   = step_reg;
        thr_next    = thr_reg;
        if (cfg_write)
        begin
            unique case (cfg.index)
                fsmd_pkg::REG_FRAME_WIDTH:      width_next  = cfg.data[fsmd_pkg::GEOM_W-1:0];
                fsmd_pkg::REG_FRAME_HEIGHT:     height_next = cfg.data[fsmd_pkg::GEOM_W-1:0];
                fsmd_pkg::REG_SUBSAMPLE_STEP:   step_next   = cfg.data[fsmd_pkg::STEP_W-1:0];
                fsmd_pkg::REG_MOTION_THRESHOLD: thr_next    = cfg.data[fsmd_pkg::THR_W-1:0];
                default:                        ;   // unknown index: only restarts frames
            endcase
        end
    end

    // clamp geometry and step into their legal ranges
    logic [fsmd_pkg::GEOM_W-1:0]  width_eff, height_eff;
    logic [fsmd_pkg::STEP_W-1:0]  step_eff;
    logic [fsmd_pkg::PHASE_W-1:0] step_m1;

    always_comb
    begin
        width_eff  = (width_reg == '0) ? fsmd_pkg::GEOM_W'(1) :
                     (width_reg > fsmd_pkg::GEOM_MAX) ? fsmd_pkg::GEOM_MAX : width_reg;
        height_eff = (height_reg == '0) ? fsmd_pkg::GEOM_W'(1) :
                     (height_reg > fsmd_pkg::GEOM_MAX) ? fsmd_pkg::GEOM_MAX : height_reg;
        step_eff   = (step_reg == '0) ? fsmd_pkg::STEP_W'(1) :
                     (step_reg > fsmd_pkg::STEP_MAX) ? fsmd_pkg::STEP_MAX : step_reg;
        step_m1    = fsmd_pkg::PHASE_W'(step_eff - fsmd_pkg::STEP_W'(1));
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    //   s1: RAM data back, SAD accumulate, write-back
    //   s2: threshold compare
    //   out: result register
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s1_last_reg;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_fire, s2_go, s2_free, s1_go, s1_free, in_accept;

    assign out_fire  = out_valid_reg & result_out.ready;
    assign s2_go     = s2_valid_reg & (~out_valid_reg | result_out.ready);
    assign s2_free   = ~s2_valid_reg | s2_go;
    assign s1_go     = s1_valid_reg & (~s1_last_reg | s2_free);
    assign s1_free   = ~s1_valid_reg | s1_go;

    assign pixel_in.ready = s1_free;
    assign in_accept      = pixel_in.valid & s1_free;

    // ------------------------------------------------------------------
    // Raster position, sampling phase and sample index (stage 0)
    // ------------------------------------------------------------------
    logic [fsmd_pkg::POS_W-1:0]   col_reg,       col_next;
    logic [fsmd_pkg::POS_W-1:0]   row_reg,       row_next;
    logic [fsmd_pkg::PHASE_W-1:0] col_phase_reg, col_phase_next;
    logic [fsmd_pkg::PHASE_W-1:0] row_phase_reg, row_phase_next;
    logic [fsmd_pkg::SIDX_W-1:0]  sidx_reg,      sidx_next;
    logic                         ref_valid_reg, ref_valid_next;

    logic                         sampled, last_col, last_row, frame_end;
    logic [fsmd_pkg::SIDX_W-1:0]  sidx_inc;

    always_comb
    begin
        sampled   = (col_phase_reg == '0) && (row_phase_reg == '0) &&
                    (sidx_reg < fsmd_pkg::SIDX_W'(fsmd_pkg::MAX_SAMPLES));
        last_col  = (fsmd_pkg::GEOM_W'(col_reg) + fsmd_pkg::GEOM_W'(1)) >= width_eff;
        last_row  = (fsmd_pkg::GEOM_W'(row_reg) + fsmd_pkg::GEOM_W'(1)) >= height_eff;
        frame_end = last_col & last_row;
        sidx_inc  = sidx_reg + fsmd_pkg::SIDX_W'(sampled);
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        sidx_next      = sidx_reg;
        ref_valid_next = ref_valid_reg;
        priority if (cfg_write)
        begin
            col_next       = '0;
            row_next       = '0;
            col_phase_next = '0;
            row_phase_next = '0;
            sidx_next      = '0;
            ref_valid_next = 1'b0;
        end
        else if (in_accept)
        begin
            if (!last_col)
            begin
                col_next       = col_reg + fsmd_pkg::POS_W'(1);
                col_phase_next = (col_phase_reg == step_m1) ? '0 :
                                 col_phase_reg + fsmd_pkg::PHASE_W'(1);
            end
            else
            begin
                col_next       = '0;
                col_phase_next = '0;
                if (!last_row)
                begin
                    row_next       = row_reg + fsmd_pkg::POS_W'(1);
                    row_phase_next = (row_phase_reg == step_m1) ? '0 :
                                     row_phase_reg + fsmd_pkg::PHASE_W'(1);
                end
                else
                begin
                    row_next       = '0;
                    row_phase_next = '0;
                end
            end
            sidx_next      = frame_end ? '0 : sidx_inc;
            ref_valid_next = frame_end ? 1'b1 : ref_valid_reg;
        end
        else
        begin
            // no transaction: position holds
        end
    end

    // ------------------------------------------------------------------
    // Sample store
    // ------------------------------------------------------------------
    logic                         ram_we;
    logic [fsmd_pkg::ADDR_W-1:0]  ram_waddr;
    fsmd_pkg::pixel_t             ram_wdata;
    fsmd_pkg::pixel_t             ram_rdata;
    logic [fsmd_pkg::ADDR_W-1:0]  rd_addr;

    assign rd_addr = sidx_reg[fsmd_pkg::ADDR_W-1:0];

    fsmd_ram #(
        .WIDTH (fsmd_pkg::PIX_W),
        .DEPTH (fsmd_pkg::MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 payload
    // ------------------------------------------------------------------
    fsmd_pkg::pixel_t             s1_pix_reg,     s1_pix_next;
    logic [fsmd_pkg::ADDR_W-1:0]  s1_addr_reg,    s1_addr_next;
    logic                         s1_sampled_reg, s1_sampled_next;
    logic                         s1_ref_reg,     s1_ref_next;
    logic                         s1_last_next;
    logic [fsmd_pkg::SIDX_W-1:0]  s1_count_reg,   s1_count_next;
    logic                         s1_fwd_reg,     s1_fwd_next;
    fsmd_pkg::pixel_t             s1_fwd_data_reg, s1_fwd_data_next;
    logic [fsmd_pkg::SAD_W-1:0]   acc_reg,        acc_next;

    fsmd_pkg::pixel_t             old_pix;
    logic [fsmd_pkg::DIFF_W-1:0]  pix_diff;
    logic [fsmd_pkg::SAD_W-1:0]   acc_sum;

    always_comb
    begin
        s1_valid_next    = s1_go ? 1'b0 : s1_valid_reg;
        s1_pix_next      = s1_pix_reg;
        s1_addr_next     = s1_addr_reg;
        s1_sampled_next  = s1_sampled_reg;
        s1_ref_next      = s1_ref_reg;
        s1_last_next     = s1_last_reg;
        s1_count_next    = s1_count_reg;
        s1_fwd_next      = s1_fwd_reg;
        s1_fwd_data_next = s1_fwd_data_reg;
        if (in_accept)
        begin
            s1_valid_next    = 1'b1;
            s1_pix_next      = {pixel_in.red, pixel_in.green, pixel_in.blue};
            s1_addr_next     = rd_addr;
            s1_sampled_next  = sampled;
            s1_ref_next      = ref_valid_reg;
            s1_last_next     = frame_end;
            s1_count_next    = sidx_inc;
            // same entry written by the item leaving stage 1 this cycle
            s1_fwd_next      = ram_we && (ram_waddr == rd_addr);
            s1_fwd_data_next = s1_pix_reg;
        end
    end

    always_comb
    begin
        old_pix   = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
        pix_diff  = fsmd_pkg::DIFF_W'(fsmd_pkg::abs_diff8(s1_pix_reg[23:16], old_pix[23:16]))
                  + fsmd_pkg::DIFF_W'(fsmd_pkg::abs_diff8(s1_pix_reg[15:8],  old_pix[15:8]))
                  + fsmd_pkg::DIFF_W'(fsmd_pkg::abs_diff8(s1_pix_reg[7:0],   old_pix[7:0]));
        acc_sum   = acc_reg + ((s1_sampled_reg && s1_ref_reg) ?
                               fsmd_pkg::SAD_W'(pix_diff) : '0);
        ram_we    = s1_go & s1_sampled_reg;
        ram_waddr = s1_addr_reg;
        ram_wdata = s1_pix_reg;

        acc_next = acc_reg;
        priority if (cfg_write)
        begin
            acc_next = '0;
        end
        else if (s1_go)
        begin
            acc_next = s1_last_reg ? '0 : acc_sum;
        end
        else
        begin
            // stage 1 empty or held: total holds
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: frame total and threshold product
    // ------------------------------------------------------------------
    logic [fsmd_pkg::SAD_W-1:0]   s2_total_reg, s2_total_next;
    logic [fsmd_pkg::SIDX_W-1:0]  s2_count_reg, s2_count_next;
    logic                         s2_ref_reg,   s2_ref_next;
    logic [fsmd_pkg::PROD_W-1:0]  s2_prod_reg,  s2_prod_next;

    always_comb
    begin
        s2_valid_next = s2_go ? 1'b0 : s2_valid_reg;
        s2_total_next = s2_total_reg;
        s2_count_next = s2_count_reg;
        s2_ref_next   = s2_ref_reg;
        s2_prod_next  = s2_prod_reg;
        if (s1_go && s1_last_reg)
        begin
            s2_valid_next = 1'b1;
            s2_total_next = acc_sum;
            s2_count_next = s1_count_reg;
            s2_ref_next   = s1_ref_reg;
            s2_prod_next  = fsmd_pkg::PROD_W'(thr_reg) * fsmd_pkg::PROD_W'(s1_count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                          out_motion_reg, out_motion_next;
    logic [fsmd_pkg::SAD_W-1:0]    out_total_reg,  out_total_next;
    logic [fsmd_pkg::COUNT_W-1:0]  out_count_reg,  out_count_next;
    logic                          out_ref_reg,    out_ref_next;

    always_comb
    begin
        out_valid_next  = s2_go ? 1'b1 : (out_fire ? 1'b0 : out_valid_reg);
        out_motion_next = out_motion_reg;
        out_total_next  = out_total_reg;
        out_count_next  = out_count_reg;
        out_ref_next    = out_ref_reg;
        if (s2_go)
        begin
            out_motion_next = s2_ref_reg && (s2_count_reg != '0) &&
                              (fsmd_pkg::PROD_W'(s2_total_reg) >= s2_prod_reg);
            out_total_next  = s2_ref_reg ? s2_total_reg : '0;
            out_count_next  = fsmd_pkg::COUNT_W'(s2_count_reg);
            out_ref_next    = s2_ref_reg;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.motion        = out_motion_reg;
    assign result_out.sad_total     = out_total_reg;
    assign result_out.sample_count  = out_count_reg;
    assign result_out.had_reference = out_ref_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= fsmd_pkg::RESET_WIDTH;
            height_reg    <= fsmd_pkg::RESET_HEIGHT;
            step_reg      <= fsmd_pkg::RESET_STEP;
            thr_reg       <= fsmd_pkg::RESET_THR;
            col_reg       <= '0;
            row_reg       <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            sidx_reg      <= '0;
            ref_valid_reg <= 1'b0;
            acc_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            step_reg      <= step_next;
            thr_reg       <= thr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            sidx_reg      <= sidx_next;
            ref_valid_reg <= ref_valid_next;
            acc_reg       <= acc_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        s1_pix_reg      <= s1_pix_next;
        s1_addr_reg     <= s1_addr_next;
        s1_sampled_reg  <= s1_sampled_next;
        s1_ref_reg      <= s1_ref_next;
        s1_last_reg     <= s1_last_next;
        s1_count_reg    <= s1_count_next;
        s1_fwd_reg      <= s1_fwd_next;
        s1_fwd_data_reg <= s1_fwd_data_next;
        s2_total_reg    <= s2_total_next;
        s2_count_reg    <= s2_count_next;
        s2_ref_reg      <= s2_ref_next;
        s2_prod_reg     <= s2_prod_next;
        out_motion_reg  <= out_motion_next;
        out_total_reg   <= out_total_next;
        out_count_reg   <= out_count_next;
        out_ref_reg     <= out_ref_next;
    end

endmodule

`default_nettype wire
